@@ hdl/baro_temp_compensation_unit_macros.svh @@
// Assertion macros for the compensation block.
`ifndef BARO_TEMP_COMPENSATION_UNIT_MACROS_SVH
`define BARO_TEMP_COMPENSATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btc assertion failed");
`define BTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btc assertion failed");
`else
`define BTC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BTC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hdl/btc_pkg.sv @@
package btc_pkg;

  localparam int FRAC_IN = 24;
  localparam int Q_W = 57;
  localparam int B_W = 32;
  localparam int RAW_W = 24;
  localparam int DIV_W = 48;
  localparam int RESULT_FRAC_BITS_DEF = 8;

  localparam logic [RAW_W-1:0] EMPTY_WORD = 24'h800000;

  localparam logic [1:0] CMD_PRES = 2'd1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_NO_TEMP = 2'd2;

  localparam logic [2:0] CFG_TEMP_COEFS   = 3'd0;
  localparam logic [2:0] CFG_PRES_COEFS_A = 3'd1;
  localparam logic [2:0] CFG_PRES_COEFS_B = 3'd2;
  localparam logic [2:0] CFG_TEMP_SCALE   = 3'd3;
  localparam logic [2:0] CFG_PRES_SCALE   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_WAIT, S_MUL_START, S_MUL_WAIT, S_SUM, S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_T, ST_C30, ST_Q2, ST_Q3, ST_C21, ST_SP, ST_ST, ST_C01
  } mul_step_t;

  function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W+1:0] v);
    logic signed [Q_W+1:0] lim;
    logic signed [Q_W+1:0] nlim;
    lim = (Q_W+2)'(1) <<< (Q_W-2);
    nlim = -lim;
    if (v > lim) return lim[Q_W-1:0];
    if (v < nlim) return nlim[Q_W-1:0];
    return v[Q_W-1:0];
  endfunction

endpackage

@@ hdl/baro_temp_compensation_unit.sv @@
// A temperature word runs through a 48-step bit-serial divider and one product; a
// pressure word runs through the divider and seven products. All products share
// one 32-step serial multiplier. A FIFO empty word or pressure without temperature
// bypasses both and goes straight to the result.
// One word in flight; the next word can be accepted the cycle after the result is taken.
// Synchronous reset clears control, coefficients and kept temperature, and sets both scales to 524288.
`include "baro_temp_compensation_unit_macros.svh"

module baro_temp_compensation_unit #(
  parameter int RESULT_FRAC_BITS = btc_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [23:0]         raw_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  value,
  output logic                kind,
  output logic [1:0]          status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import btc_pkg::*;

  localparam int SH = FRAC_IN - RESULT_FRAC_BITS;
  localparam logic signed [Q_W:0] HALF = (Q_W+1)'(1) <<< (SH-1);
  localparam logic signed [Q_W:0] MAXV = (Q_W+1)'(32'h7FFFFFFF);
  localparam logic signed [Q_W:0] MINV = -MAXV - (Q_W+1)'(1);

  state_t     state, state_next;
  mul_step_t  step;

  logic [23:0] temp_coefs;
  logic [55:0] pres_coefs_a;
  logic [63:0] pres_coefs_b;
  logic [23:0] temp_scale;
  logic [23:0] pres_scale;

  logic              temp_seen;
  logic signed [31:0] t_scaled;
  logic signed [31:0] p_scaled;
  logic              is_pres;
  logic              is_neg;
  logic signed [Q_W-1:0] qreg, rreg, sreg, ureg, tot;

  // accept decode
  logic              accept, w_fifo, w_empty, w_pres, w_early;
  logic [RAW_W-1:0]  w_mag, w_scale, w_den;
  logic [DIV_W-1:0]  w_num;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [31:0]       sat_mag;
  logic signed [31:0] scaled;

  logic              mul_start, mul_done;
  logic signed [Q_W-1:0] mul_a, mul_res;
  logic signed [B_W-1:0] mul_b;

  logic signed [Q_W-1:0] c0q, c1q, c00q, c10q, c01q, c11q, c20q, c21q, c30q;
  logic signed [Q_W:0]   rnd, xs;
  logic signed [31:0]    fin_val;

  assign accept  = in_valid && in_ready;
  assign w_fifo  = cmd[1];
  assign w_empty = w_fifo && (raw_word == EMPTY_WORD);
  assign w_pres  = w_fifo ? raw_word[0] : (cmd == CMD_PRES);
  assign w_early = w_empty || (w_pres && !temp_seen);
  assign w_mag   = raw_word[RAW_W-1] ? -raw_word : raw_word;
  assign w_scale = w_pres ? pres_scale : temp_scale;
  assign w_den   = (w_scale == '0) ? RAW_W'(1) : w_scale;
  assign w_num   = {w_mag, {FRAC_IN{1'b0}}} + DIV_W'(w_den >> 1);

  assign c0q  = Q_W'($signed({temp_coefs[23:12], 23'b0}));
  assign c1q  = Q_W'($signed({temp_coefs[11:0], 24'b0}));
  assign c00q = Q_W'($signed({pres_coefs_a[55:36], 24'b0}));
  assign c10q = Q_W'($signed({pres_coefs_a[35:16], 24'b0}));
  assign c01q = Q_W'($signed({pres_coefs_a[15:0], 24'b0}));
  assign c11q = Q_W'($signed({pres_coefs_b[63:48], 24'b0}));
  assign c20q = Q_W'($signed({pres_coefs_b[47:32], 24'b0}));
  assign c21q = Q_W'($signed({pres_coefs_b[31:16], 24'b0}));
  assign c30q = Q_W'($signed({pres_coefs_b[15:0], 24'b0}));

  btc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (w_num),
    .den  (w_den),
    .done (div_done),
    .quo  (div_quo)
  );

  btc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_res)
  );

  // quotient saturation and sign
  always_comb begin
    if (is_neg) begin
      sat_mag = (div_quo > DIV_W'(32'h80000000)) ? 32'h80000000 : div_quo[31:0];
      scaled  = -$signed(sat_mag);
    end else begin
      sat_mag = (div_quo > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_quo[31:0];
      scaled  = $signed(sat_mag);
    end
  end

  always_comb begin
    unique case (step)
      ST_T:   begin mul_a = c1q;  mul_b = t_scaled; end
      ST_C30: begin mul_a = c30q; mul_b = p_scaled; end
      ST_Q2:  begin mul_a = qreg; mul_b = p_scaled; end
      ST_Q3:  begin mul_a = qreg; mul_b = p_scaled; end
      ST_C21: begin mul_a = c21q; mul_b = p_scaled; end
      ST_SP:  begin mul_a = sreg; mul_b = p_scaled; end
      ST_ST:  begin mul_a = sreg; mul_b = t_scaled; end
      ST_C01: begin mul_a = c01q; mul_b = t_scaled; end
      default: begin mul_a = c1q; mul_b = t_scaled; end
    endcase
  end

  assign rnd = (Q_W+1)'(tot) + HALF;
  assign xs  = rnd >>> SH;
  always_comb begin
    if (xs > MAXV) fin_val = 32'sh7FFFFFFF;
    else if (xs < MINV) fin_val = 32'sh80000000;
    else fin_val = xs[31:0];
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (w_early) begin
            state_next = S_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV_WAIT;
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = S_MUL_START;
      end
      S_MUL_START: begin
        mul_start  = 1'b1;
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          if (step == ST_T) state_next = S_FIN;
          else if (step == ST_C01) state_next = S_SUM;
          else state_next = S_MUL_START;
        end
      end
      S_SUM: state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coefs   <= '0;
      pres_coefs_a <= '0;
      pres_coefs_b <= '0;
      temp_scale   <= 24'd524288;
      pres_scale   <= 24'd524288;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_COEFS:   temp_coefs   <= cfg_data[23:0];
        CFG_PRES_COEFS_A: pres_coefs_a <= cfg_data[55:0];
        CFG_PRES_COEFS_B: pres_coefs_b <= cfg_data;
        CFG_TEMP_SCALE:   temp_scale   <= cfg_data[23:0];
        CFG_PRES_SCALE:   pres_scale   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_seen <= 1'b0;
      t_scaled  <= '0;
    end else if (state == S_DIV_WAIT && div_done && !is_pres) begin
      temp_seen <= 1'b1;
      t_scaled  <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_pres <= w_pres && !w_empty;
      is_neg  <= raw_word[RAW_W-1];
      step    <= (w_pres && !w_empty) ? ST_C30 : ST_T;
      kind    <= w_pres && !w_empty;
      value   <= '0;
      if (w_empty) status <= STAT_EMPTY;
      else if (w_pres && !temp_seen) status <= STAT_NO_TEMP;
      else status <= STAT_OK;
    end
    if (state == S_DIV_WAIT && div_done && is_pres) p_scaled <= scaled;
    if (state == S_MUL_WAIT && mul_done) begin
      unique case (step)
        ST_T:   tot  <= clamp_q((Q_W+2)'(c0q) + (Q_W+2)'(mul_res));
        ST_C30: qreg <= clamp_q((Q_W+2)'(c20q) + (Q_W+2)'(mul_res));
        ST_Q2:  qreg <= clamp_q((Q_W+2)'(c10q) + (Q_W+2)'(mul_res));
        ST_Q3:  rreg <= mul_res;
        ST_C21: sreg <= clamp_q((Q_W+2)'(c11q) + (Q_W+2)'(mul_res));
        ST_SP:  sreg <= mul_res;
        ST_ST:  sreg <= mul_res;
        ST_C01: ureg <= mul_res;
        default: ;
      endcase
      if (step != ST_T && step != ST_C01) step <= mul_step_t'(step + 3'd1);
    end
    if (state == S_SUM) begin
      tot <= clamp_q((Q_W+2)'(c00q) + (Q_W+2)'(rreg) + (Q_W+2)'(ureg)
                     + (Q_W+2)'(sreg));
    end
    if (state == S_FIN) value <= fin_val;
  end

  `BTC_ASSERT_IMP(a_ready_excl, clk, rst, in_ready, !out_valid)
  `BTC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `BTC_ASSERT_IMP(a_flag_zero, clk, rst, out_valid && status != STAT_OK, value == 32'sd0)

endmodule

@@ hdl/btc_div.sv @@
module btc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [btc_pkg::DIV_W-1:0]   num,
  input  logic [btc_pkg::RAW_W-1:0]   den,
  output logic                        done,
  output logic [btc_pkg::DIV_W-1:0]   quo
);
  import btc_pkg::*;

  logic                 busy;
  logic [5:0]           cnt;
  logic [RAW_W-1:0]     rem;
  logic [RAW_W-1:0]     dreg;
  logic [RAW_W:0]       rem_sh;
  logic [RAW_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dreg};
  assign ge     = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_W-1);
        rem  <= '0;
        dreg <= den;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/btc_mul.sv @@
module btc_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [btc_pkg::Q_W-1:0]    a,
  input  logic signed [btc_pkg::B_W-1:0]    b,
  output logic                              done,
  output logic signed [btc_pkg::Q_W-1:0]    prod
);
  import btc_pkg::*;

  localparam int P_W = Q_W + B_W;
  localparam logic signed [P_W-1:0] LIM =
    {{(P_W-Q_W+1){1'b0}}, 1'b1, {(Q_W-2){1'b0}}};
  localparam logic signed [P_W-1:0] NLIM = -LIM;

  logic                     busy;
  logic [4:0]               cnt;
  logic signed [Q_W-1:0]    areg;
  logic [B_W-1:0]           breg;
  logic signed [P_W-1:0]    acc;
  logic signed [P_W-1:0]    a_ext;
  logic signed [P_W-1:0]    term;
  logic signed [P_W-1:0]    sh;

  assign a_ext = P_W'(areg);

  always_comb begin
    if (!breg[cnt]) term = '0;
    else if (cnt == 5'(B_W-1)) term = -a_ext;
    else term = a_ext;
  end

  // floor of the Q.24 product, then limit to +-2^55
  assign sh = acc >>> FRAC_IN;
  always_comb begin
    if (sh > LIM) prod = LIM[Q_W-1:0];
    else if (sh < NLIM) prod = NLIM[Q_W-1:0];
    else prod = sh[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(B_W-1);
        areg <= a;
        breg <= b;
        acc  <= '0;
      end else if (busy) begin
        acc <= (acc <<< 1) + term;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
